// ===== hw/rtl/mbps_pkg.sv =====
package mbps_pkg;

  localparam int unsigned PatternMaxDef  = 16;
  localparam int unsigned StreamLimitDef = 1024 * 1024 * 1024;

  // Fixed field widths
  localparam int unsigned AddrW   = 64;
  localparam int unsigned LenW    = 5;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned OffW    = 30;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBaseAddress = 3'd0,
    CfgPatternLow  = 3'd1,
    CfgPatternHigh = 3'd2,
    CfgCareMask    = 3'd3,
    CfgPatternLen  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } out_t;

endpackage

// ===== hw/rtl/masked_byte_pattern_search.sv =====
// Masked byte pattern search. One byte item is accepted per clock cycle while
// in_ready_o is high; the window shift, the masked compare at every pattern
// length and the address add all sit between the stream state registers and
// the result register, so the result for a region appears on out_valid_o in
// the cycle after its last byte is accepted. The result register decouples the
// two sides: in_ready_o drops only while a result is held and out_ready_i is
// low. Configuration is a plain write port (cfg_we_i, cfg_index_i,
// cfg_wdata_i); indexes beyond the register list are ignored.
module masked_byte_pattern_search #(
  parameter int unsigned PATTERN_MAX  = mbps_pkg::PatternMaxDef,
  parameter int unsigned STREAM_LIMIT = mbps_pkg::StreamLimitDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mbps_pkg::AddrW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mbps_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mbps_pkg::out_t                 out_data_o
);

  // Count saturates at STREAM_LIMIT + 1
  localparam int unsigned CntW = $clog2(STREAM_LIMIT + 2);

  logic [mbps_pkg::AddrW-1:0] base_q, pat_lo_q, pat_hi_q;
  logic [mbps_pkg::MaskW-1:0] care_q;
  logic [mbps_pkg::LenW-1:0]  plen_q;

  logic [PATTERN_MAX-1:0][7:0] win_q, win_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        hit_q, hit_d;
  logic [mbps_pkg::OffW-1:0]   off_q, off_d;

  logic           out_valid_q;
  mbps_pkg::out_t out_q, out_d;

  logic [15:0][7:0]        pat;
  logic [mbps_pkg::LenW-1:0] len;
  logic [PATTERN_MAX:0]    match_vec;
  logic                    match_sel;
  logic [31:0]             cnt32, diff32;
  logic                    in_range;
  logic                    accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pat = {pat_hi_q, pat_lo_q};
  assign len = (plen_q > mbps_pkg::LenW'(PATTERN_MAX)) ? mbps_pkg::LenW'(PATTERN_MAX) : plen_q;

  always_comb begin
    win_d[0] = in_data_i.data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  assign cnt_d    = (cnt_q <= CntW'(STREAM_LIMIT)) ? cnt_q + CntW'(1) : cnt_q;
  assign cnt32    = 32'(cnt_d);
  assign diff32   = cnt32 - 32'(len);
  assign in_range = cnt32 <= 32'(STREAM_LIMIT);

  // Match flag for every candidate length; pattern byte j aligns with the
  // byte L-1-j items back.
  always_comb begin
    match_vec[0] = 1'b1;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      match_vec[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (care_q[j] && (win_d[l-1-j] != pat[j])) begin
          match_vec[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    match_sel = 1'b0;
    for (int l = 0; l <= PATTERN_MAX; l++) begin
      if (len == mbps_pkg::LenW'(l)) begin
        match_sel = match_vec[l];
      end
    end
  end

  always_comb begin
    hit_d = hit_q;
    off_d = off_q;
    if (!hit_q && in_range) begin
      if (len == '0) begin
        hit_d = 1'b1;
        off_d = '0;
      end else if ((cnt32 >= 32'(len)) && match_sel) begin
        hit_d = 1'b1;
        off_d = diff32[mbps_pkg::OffW-1:0];
      end
    end
  end

  always_comb begin
    out_d.found         = hit_d && (base_q != '0) && in_range;
    out_d.match_address = out_d.found
                          ? base_q + mbps_pkg::AddrW'(off_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      plen_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mbps_pkg::CfgBaseAddress: base_q   <= cfg_wdata_i;
        mbps_pkg::CfgPatternLow:  pat_lo_q <= cfg_wdata_i;
        mbps_pkg::CfgPatternHigh: pat_hi_q <= cfg_wdata_i;
        mbps_pkg::CfgCareMask:    care_q   <= cfg_wdata_i[mbps_pkg::MaskW-1:0];
        mbps_pkg::CfgPatternLen:  plen_q   <= cfg_wdata_i[mbps_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
      hit_q <= 1'b0;
      off_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_byte) begin
        // region done: start the next one clean
        win_q <= '0;
        cnt_q <= '0;
        hit_q <= 1'b0;
        off_q <= '0;
      end else begin
        win_q <= win_d;
        cnt_q <= cnt_d;
        hit_q <= hit_d;
        off_q <= off_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_data_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.last_byte) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
